/* hdl/ir_distance_linearizer_unit_defines.svh */
// Assertion macros for the IR distance linearizer.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef IR_DISTANCE_LINEARIZER_UNIT_DEFINES_SVH
`define IR_DISTANCE_LINEARIZER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define IDL_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("idl assertion failed");
`define IDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("idl assertion failed");
`else
`define IDL_ASSERT(lbl, ante, cons)
`define IDL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/idl_pkg.sv */
// Shared constants, types and default calibration set of the IR distance linearizer.
// No dependencies.
package idl_pkg;

  localparam int Segments      = 16;
  localparam int Sensors       = 4;
  localparam int DefaultPoints = 16;
  localparam int Points        = Segments + 1;

  localparam int PointW  = 13;
  localparam int SampleW = 12;
  localparam int DistW   = 12;
  localparam int SensorW = 2;
  localparam int MmW     = 5;
  localparam int KW      = $clog2(Points);
  localparam int SensorAw = (Sensors > 1) ? $clog2(Sensors) : 1;

  localparam int StepUnits = 200;
  localparam int StepW     = 8;
  localparam int DivBits   = 2;
  localparam int DivStages = (SampleW + StepW + DivBits - 1) / DivBits;
  localparam int QW        = DivBits * DivStages;
  localparam int RemW      = PointW + 1;

  localparam int MmMin = 2;
  localparam int MmMax = 30;

  localparam logic [DistW-1:0]  TopDist  = DistW'(StepUnits * Segments);
  localparam logic [PointW-1:0] FarPoint = 13'd5000;

  typedef enum logic {
    OpConvert   = 1'b0,
    OpCalibrate = 1'b1
  } op_e;

  localparam logic [PointW-1:0] DfltPoints [4][DefaultPoints] = '{
    '{13'd0, 13'd178, 13'd185, 13'd196, 13'd204, 13'd214, 13'd227, 13'd239,
      13'd254, 13'd269, 13'd291, 13'd324, 13'd557, 13'd882, 13'd1189, 13'd1449},
    '{13'd0, 13'd176, 13'd184, 13'd193, 13'd202, 13'd212, 13'd222, 13'd232,
      13'd241, 13'd253, 13'd267, 13'd285, 13'd318, 13'd429, 13'd760, 13'd1061},
    '{13'd0, 13'd160, 13'd170, 13'd178, 13'd189, 13'd198, 13'd207, 13'd217,
      13'd227, 13'd237, 13'd252, 13'd265, 13'd284, 13'd307, 13'd377, 13'd718},
    '{13'd0, 13'd175, 13'd184, 13'd193, 13'd203, 13'd213, 13'd224, 13'd234,
      13'd244, 13'd257, 13'd273, 13'd290, 13'd324, 13'd438, 13'd743, 13'd992}
  };

  // Power-up value of one breakpoint
  function automatic logic [PointW-1:0] dflt_point(input logic [SensorW-1:0] sensor,
                                                   input logic [KW-1:0] point);
    logic [PointW-1:0] val;
    val = FarPoint;
    if (int'(point) < Segments && int'(point) < DefaultPoints) begin
      val = DfltPoints[sensor][4'(point)];
    end
    return val;
  endfunction

  // Per-transaction control carried down the pipe
  typedef struct packed {
    logic zero;
    logic rej;
  } idl_ctl_t;

  // Result of the breakpoint search
  typedef struct packed {
    logic                valid;
    idl_ctl_t            ctl;
    logic [KW-1:0]       k;
    logic [PointW-1:0]   lo;
    logic [PointW-1:0]   hi;
    logic [SampleW-1:0]  sample;
  } idl_srch_t;

  typedef struct packed {
    idl_ctl_t           ctl;
    logic               sat;
    logic [DistW-1:0]   base;
  } idl_side_t;

  // Divider stage contents
  typedef struct packed {
    idl_side_t          side;
    logic [QW-1:0]      num;
    logic [RemW-1:0]    rem;
    logic [QW-1:0]      quo;
    logic [PointW-1:0]  span;
  } idl_div_t;

endpackage

/* hdl/idl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module idl_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/idl_lookup.sv */
// Breakpoint tables and segment search: two pipeline stages.
// Depends on idl_pkg and idl_ram.
module idl_lookup (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            rd_i,
  input  logic [idl_pkg::SensorW-1:0]     rd_sensor_i,
  input  logic [idl_pkg::SampleW-1:0]     rd_sample_i,
  input  idl_pkg::idl_ctl_t               rd_ctl_i,
  input  logic                            we_i,
  input  logic [idl_pkg::SensorW-1:0]     wr_sensor_i,
  input  logic [idl_pkg::KW-1:0]          wr_point_i,
  input  logic [idl_pkg::PointW-1:0]      wr_data_i,
  output idl_pkg::idl_srch_t              srch_o
);

  logic [idl_pkg::Sensors-1:0][idl_pkg::Points-1:0] vld_q;
  logic [idl_pkg::PointW-1:0] rdata [idl_pkg::Points];

  logic                         s1_valid_q;
  idl_pkg::idl_ctl_t            s1_ctl_q;
  logic [idl_pkg::SensorW-1:0]  s1_sensor_q;
  logic [idl_pkg::SampleW-1:0]  s1_sample_q;
  logic [idl_pkg::Points-1:0]   s1_pvld_q;

  logic [idl_pkg::PointW-1:0]   pt [idl_pkg::Points];
  idl_pkg::idl_srch_t           srch_d, srch_q;
  logic                         srch_valid_q;

  // One RAM per breakpoint, addressed by sensor
  for (genvar p = 0; p < idl_pkg::Points; p++) begin : g_point
    idl_ram #(
      .Width (idl_pkg::PointW),
      .Depth (idl_pkg::Sensors)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we_i && (int'(wr_point_i) == p)),
      .waddr_i (idl_pkg::SensorAw'(wr_sensor_i)),
      .wdata_i (wr_data_i),
      .re_i    (rd_i),
      .raddr_i (idl_pkg::SensorAw'(rd_sensor_i)),
      .rdata_o (rdata[p])
    );

    // Fall back to the default set until an entry is written
    assign pt[p] = s1_pvld_q[p] ? rdata[p]
                                : idl_pkg::dflt_point(s1_sensor_q, idl_pkg::KW'(p));
  end

  // Mark written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[idl_pkg::SensorAw'(wr_sensor_i)][wr_point_i] <= 1'b1;
    end
  end

  // Stage 1: table read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= rd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i) begin
      s1_ctl_q    <= rd_ctl_i;
      s1_sensor_q <= rd_sensor_i;
      s1_sample_q <= rd_sample_i;
      s1_pvld_q   <= vld_q[idl_pkg::SensorAw'(rd_sensor_i)];
    end
  end

  // Find the first point above the sample and pick the segment ends
  always_comb begin
    logic [idl_pkg::KW-1:0] k;
    k = idl_pkg::KW'(idl_pkg::Segments);
    for (int i = idl_pkg::Segments - 1; i >= 0; i--) begin
      if (pt[i] > {1'b0, s1_sample_q}) begin
        k = idl_pkg::KW'(i);
      end
    end
    srch_d          = '0;
    srch_d.valid    = s1_valid_q;
    srch_d.ctl      = s1_ctl_q;
    srch_d.ctl.zero = s1_ctl_q.zero || (k == '0);
    srch_d.k        = k;
    srch_d.hi       = pt[k];
    srch_d.lo       = (k == '0) ? '0 : pt[k - 1'b1];
    srch_d.sample   = s1_sample_q;
  end

  // Stage 2: search result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_valid_q <= 1'b0;
    end else if (en_i) begin
      srch_valid_q <= srch_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && srch_d.valid) begin
      srch_q <= srch_d;
    end
  end

  // Present the held result with its own valid bit
  always_comb begin
    srch_o       = srch_q;
    srch_o.valid = srch_valid_q;
  end

endmodule

/* hdl/idl_div.sv */
// Pipelined restoring divider, DivBits quotient bits per stage.
// Depends on idl_pkg.
module idl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  idl_pkg::idl_div_t  div_i,
  output logic               out_valid_o,
  output idl_pkg::idl_div_t  div_o
);

  logic [idl_pkg::DivStages-1:0] vld_q;
  idl_pkg::idl_div_t             st_q [idl_pkg::DivStages];

  for (genvar s = 0; s < idl_pkg::DivStages; s++) begin : g_stage
    idl_pkg::idl_div_t src, nxt;
    logic              src_v;

    if (s == 0) begin : g_first
      assign src   = div_i;
      assign src_v = in_valid_i;
    end else begin : g_rest
      assign src   = st_q[s-1];
      assign src_v = vld_q[s-1];
    end

    // Shift in numerator bits and trial-subtract the span
    always_comb begin
      logic [idl_pkg::RemW-1:0] r;
      logic [idl_pkg::QW-1:0]   n;
      logic [idl_pkg::QW-1:0]   q;
      logic                     ge;
      r = src.rem;
      n = src.num;
      q = src.quo;
      for (int b = 0; b < idl_pkg::DivBits; b++) begin
        r  = {r[idl_pkg::RemW-2:0], n[idl_pkg::QW-1]};
        n  = {n[idl_pkg::QW-2:0], 1'b0};
        ge = (r >= {1'b0, src.span});
        if (ge) begin
          r = r - {1'b0, src.span};
        end
        q = {q[idl_pkg::QW-2:0], ge};
      end
      nxt      = src;
      nxt.rem  = r;
      nxt.num  = n;
      nxt.quo  = q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i && src_v) begin
        st_q[s] <= nxt;
      end
    end
  end

  assign out_valid_o = vld_q[idl_pkg::DivStages-1];
  assign div_o       = st_q[idl_pkg::DivStages-1];

endmodule

/* hdl/ir_distance_linearizer_unit.sv */
// Top level of the IR distance linearizer: decode, interpolation setup, output register.
// Depends on idl_pkg, idl_lookup, idl_div and the assertion macro header.
//
//  channel | direction | handshake             | fields
//  in      | to block  | in_valid_i/in_stall_o | op, sensor, sample, cal_distance_mm, cal_value
//  out     | from block| out_valid_o/out_stall_i | distance, saturated, write_rejected
//
// One transaction enters per cycle unless the output stalls; pipe order: table read,
// search, stage 3 setup, divider at two quotient bits per stage, output register.
// Reset clears all valid bits; tables read the default set until written.
// A stalled output freezes the whole pipe; in_stall_o follows out_stall_i then.
`include "ir_distance_linearizer_unit_defines.svh"
module ir_distance_linearizer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [idl_pkg::SensorW-1:0]   sensor_i,
  input  logic [idl_pkg::SampleW-1:0]   sample_i,
  input  logic [idl_pkg::MmW-1:0]       cal_distance_mm_i,
  input  logic [idl_pkg::PointW-1:0]    cal_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [idl_pkg::DistW-1:0]     distance_o,
  output logic                          saturated_o,
  output logic                          write_rejected_o
);

  logic                     en, acc;
  logic                     sens_ok, mm_ok, cal_ok, is_cal, we;
  int                       idx;
  idl_pkg::idl_ctl_t        in_ctl;
  idl_pkg::idl_srch_t       srch;
  idl_pkg::idl_div_t        s3_d, s3_q;
  logic                     s3_valid_q;
  logic                     div_valid;
  idl_pkg::idl_div_t        div_out;
  logic [idl_pkg::QW:0]     sum;
  logic                     out_valid_q;
  logic [idl_pkg::DistW-1:0] dist_d, dist_q;
  logic                     sat_d, sat_q, rej_q;

  // Advance the whole pipe unless the output holds a stalled result
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign acc        = in_valid_i && en;

  // Decode the calibrate write
  always_comb begin
    is_cal  = (idl_pkg::op_e'(op_i) == idl_pkg::OpCalibrate);
    sens_ok = int'(sensor_i) < idl_pkg::Sensors;
    mm_ok   = (int'(cal_distance_mm_i) >= idl_pkg::MmMin) &&
              (int'(cal_distance_mm_i) <= idl_pkg::MmMax);
    idx     = int'(cal_distance_mm_i[idl_pkg::MmW-1:1]) - 1;
    cal_ok  = sens_ok && mm_ok && (idx <= idl_pkg::Segments);
    we      = acc && is_cal && cal_ok;
    in_ctl.zero = is_cal || !sens_ok;
    in_ctl.rej  = is_cal && !cal_ok;
  end

  idl_lookup u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .rd_i        (acc),
    .rd_sensor_i (sensor_i),
    .rd_sample_i (sample_i),
    .rd_ctl_i    (in_ctl),
    .we_i        (we),
    .wr_sensor_i (sensor_i),
    .wr_point_i  (idl_pkg::KW'(idx)),
    .wr_data_i   (cal_value_i),
    .srch_o      (srch)
  );

  // Stage 3: span, scaled offset and segment base
  always_comb begin
    logic                          bad;
    logic [idl_pkg::SampleW-1:0]   diff;
    bad  = (srch.hi <= srch.lo);
    diff = idl_pkg::SampleW'({1'b0, srch.sample} - srch.lo);
    s3_d           = '0;
    s3_d.side.ctl  = srch.ctl;
    s3_d.side.sat  = bad;
    s3_d.side.base = idl_pkg::DistW'(idl_pkg::StepUnits * (int'(srch.k) - 1));
    s3_d.num       = idl_pkg::QW'(diff) * idl_pkg::QW'(idl_pkg::StepUnits);
    s3_d.span      = bad ? idl_pkg::PointW'(1) : (srch.hi - srch.lo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= srch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && srch.valid) begin
      s3_q <= s3_d;
    end
  end

  idl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s3_valid_q),
    .div_i       (s3_q),
    .out_valid_o (div_valid),
    .div_o       (div_out)
  );

  // Add the segment base and clamp
  always_comb begin
    sum    = (idl_pkg::QW + 1)'(div_out.side.base) + {1'b0, div_out.quo};
    dist_d = idl_pkg::DistW'(sum);
    sat_d  = 1'b0;
    if (div_out.side.ctl.zero) begin
      dist_d = '0;
    end else if (div_out.side.sat || (sum > (idl_pkg::QW + 1)'(idl_pkg::TopDist))) begin
      dist_d = idl_pkg::TopDist;
      sat_d  = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && div_valid) begin
      dist_q <= dist_d;
      sat_q  <= sat_d;
      rej_q  <= div_out.side.ctl.rej;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign distance_o       = dist_q;
  assign saturated_o      = sat_q;
  assign write_rejected_o = rej_q;

  `IDL_ASSERT(a_sat_top, out_valid_o && saturated_o, distance_o == idl_pkg::TopDist)
  `IDL_ASSERT(a_rej_clean, out_valid_o && write_rejected_o, !saturated_o && (distance_o == '0))
  `IDL_ASSERT(a_dist_range, out_valid_o, distance_o <= idl_pkg::TopDist)
  `IDL_ASSERT_NEXT(a_stall_holds, in_stall_o, out_valid_o)

endmodule

/* tb/tb_ir_distance_linearizer_unit.sv */
// Self-checking testbench for ir_distance_linearizer_unit: table lookup, interpolation, calibration.
// Depends on idl_pkg and the RTL of the block; no files or arguments are read.
module tb_ir_distance_linearizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    idl_pkg::op_e                op;
    logic [idl_pkg::SensorW-1:0] sensor;
    logic [idl_pkg::SampleW-1:0] sample;
    logic [idl_pkg::MmW-1:0]     mm;
    logic [idl_pkg::PointW-1:0]  value;
  } conv_item_t;

  typedef struct packed {
    logic [idl_pkg::DistW-1:0] distance;
    logic                      sat;
    logic                      rej;
  } dist_result_t;

  typedef enum int {
    PhNone    = 0,
    PhSender  = 1,
    PhRecv    = 2,
    PhBoth    = 3
  } idle_phase_e;

  localparam int LimitCycles = 400000;
  localparam int Latency     = 4 + idl_pkg::DivStages;
  localparam int LongHold    = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic op_i = 1'b0;
  logic [idl_pkg::SensorW-1:0] sensor_i = '0;
  logic [idl_pkg::SampleW-1:0] sample_i = '0;
  logic [idl_pkg::MmW-1:0] cal_distance_mm_i = '0;
  logic [idl_pkg::PointW-1:0] cal_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [idl_pkg::DistW-1:0] distance_o;
  logic saturated_o;
  logic write_rejected_o;

  ir_distance_linearizer_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .sensor_i, .sample_i,
    .cal_distance_mm_i, .cal_value_i, .out_valid_o, .out_stall_i, .distance_o,
    .saturated_o, .write_rejected_o
  );

  conv_item_t   pending_items[$];
  dist_result_t expected_dist[$];
  logic [idl_pkg::PointW-1:0] cal_table [idl_pkg::Sensors][idl_pkg::Points];
  idle_phase_e idle_phase = PhNone;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_count = 0;
  wire hold_recv = hold_req && !hold_done;
  int  errors = 0;
  int  accepted = 0;
  int  results_seen = 0;
  int  cycles = 0;
  int  n_conv = 0, n_cal = 0, n_sat = 0, n_rej = 0;

  // Clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Load the power-up calibration set
  task automatic table_reset();
    for (int s = 0; s < idl_pkg::Sensors; s++) begin
      for (int p = 0; p < idl_pkg::Points; p++) begin
        cal_table[s][p] = (p < idl_pkg::Segments && p < idl_pkg::DefaultPoints) ?
                          idl_pkg::DfltPoints[s % 4][p] : idl_pkg::FarPoint;
      end
    end
  endtask

  // Predict one transaction's result and update the table
  function automatic dist_result_t linearize(conv_item_t it);
    dist_result_t r;
    int unsigned idx, k, lo, hi, d, top;
    r = '0;
    top = idl_pkg::StepUnits * idl_pkg::Segments;
    if (it.op == idl_pkg::OpCalibrate) begin
      if (int'(it.sensor) >= idl_pkg::Sensors || it.mm < idl_pkg::MmMin ||
          it.mm > idl_pkg::MmMax) begin
        r.rej = 1'b1;
        return r;
      end
      idx = it.mm / 2 - 1;
      if (idx > idl_pkg::Segments) begin
        r.rej = 1'b1;
        return r;
      end
      cal_table[it.sensor][idx] = it.value;
      return r;
    end
    if (int'(it.sensor) >= idl_pkg::Sensors) return r;
    k = 0;
    while (k < idl_pkg::Segments && cal_table[it.sensor][k] <= it.sample) k++;
    if (k == 0) return r;
    lo = cal_table[it.sensor][k-1];
    hi = cal_table[it.sensor][k];
    if (hi <= lo) begin
      r.distance = idl_pkg::DistW'(top);
      r.sat = 1'b1;
      return r;
    end
    d = idl_pkg::StepUnits * (k - 1) + ((it.sample - lo) * idl_pkg::StepUnits) / (hi - lo);
    if (d > top) begin
      r.distance = idl_pkg::DistW'(top);
      r.sat = 1'b1;
    end else begin
      r.distance = idl_pkg::DistW'(d);
    end
    return r;
  endfunction

  function automatic conv_item_t make_item(idl_pkg::op_e op, int sensor, int sample, int mm,
                                           int value);
    conv_item_t it;
    it.op = op;
    it.sensor = idl_pkg::SensorW'(sensor);
    it.sample = idl_pkg::SampleW'(sample);
    it.mm = idl_pkg::MmW'(mm);
    it.value = idl_pkg::PointW'(value);
    return it;
  endfunction

  // Random transaction: mostly conversions, some calibrations, often with realistic values
  function automatic conv_item_t rand_item();
    conv_item_t it;
    int sel;
    it = make_item(idl_pkg::OpConvert, $urandom_range(3), $urandom_range(4095),
                   $urandom_range(31), $urandom_range(8191));
    sel = $urandom_range(99);
    if (sel < 20) begin
      it.op = idl_pkg::OpCalibrate;
      if (sel < 14) it.mm = idl_pkg::MmW'(2 + $urandom_range(28));
      if (sel < 10) it.value = idl_pkg::PointW'($urandom_range(2000));
    end else if (sel < 80) begin
      it.sample = idl_pkg::SampleW'($urandom_range(1600));
    end
    return it;
  endfunction

  // Driver: advance to the next pending transaction on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) accepted <= accepted + 1;
        if (pending_items.size() > 0 &&
            !((idle_phase == PhSender || idle_phase == PhBoth) && $urandom_range(99) < 60)) begin
          conv_item_t it;
          it = pending_items.pop_front();
          expected_dist.push_back(linearize(it));
          if (it.op == idl_pkg::OpCalibrate) n_cal++; else n_conv++;
          in_valid_i <= 1'b1;
          op_i <= it.op;
          sensor_i <= it.sensor;
          sample_i <= it.sample;
          cal_distance_mm_i <= it.mm;
          cal_value_i <= it.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted in cycles once requested
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      if (hold_count < LongHold) begin
        hold_count <= hold_count + 1;
      end else begin
        hold_done <= 1'b1;
      end
    end
  end

  // Receiver stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= hold_recv ||
        ((idle_phase == PhRecv || idle_phase == PhBoth) && $urandom_range(99) < 60);
    end
  end

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("ERROR result %0d: %s got %0d expected %0d", results_seen, what, got, exp_val);
    errors++;
  endtask

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_dist.size() == 0) begin
        report_mismatch("unexpected result, distance", distance_o, 0);
      end else begin
        dist_result_t e;
        e = expected_dist.pop_front();
        if (distance_o !== e.distance) report_mismatch("distance", distance_o, e.distance);
        if (saturated_o !== e.sat) report_mismatch("saturated", saturated_o, e.sat);
        if (write_rejected_o !== e.rej) report_mismatch("write_rejected", write_rejected_o, e.rej);
        if (e.sat) n_sat++;
        if (e.rej) n_rej++;
      end
      results_seen++;
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    if (cycles > LimitCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("ir_distance_linearizer_unit: mismatch");
      $finish;
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_dist.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    table_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, each sensor, segment edges, calibration limits
    pending_items.push_back(make_item(idl_pkg::OpConvert, 0, 0, 0, 0));
    pending_items.push_back(make_item(idl_pkg::OpConvert, 0, 4095, 31, 8191));
    pending_items.push_back(make_item(idl_pkg::OpConvert, 1, 177, 0, 0));
    pending_items.push_back(make_item(idl_pkg::OpConvert, 2, 718, 0, 0));
    pending_items.push_back(make_item(idl_pkg::OpConvert, 3, 991, 0, 0));
    pending_items.push_back(make_item(idl_pkg::OpCalibrate, 0, 0, 0, 100));
    pending_items.push_back(make_item(idl_pkg::OpCalibrate, 0, 0, 1, 100));
    pending_items.push_back(make_item(idl_pkg::OpCalibrate, 0, 0, 31, 100));
    // raise point 0 so the sample falls below the first point
    pending_items.push_back(make_item(idl_pkg::OpCalibrate, 1, 0, 2, 300));
    pending_items.push_back(make_item(idl_pkg::OpConvert, 1, 299, 0, 0));
    // flat segment: points 2 and 3 equal
    pending_items.push_back(make_item(idl_pkg::OpCalibrate, 2, 0, 6, 500));
    pending_items.push_back(make_item(idl_pkg::OpCalibrate, 2, 0, 8, 500));
    pending_items.push_back(make_item(idl_pkg::OpConvert, 2, 500, 0, 0));
    // point 14 written with the largest value, then converted inside the segment ending at it
    pending_items.push_back(make_item(idl_pkg::OpCalibrate, 3, 0, 30, 8191));
    pending_items.push_back(make_item(idl_pkg::OpCalibrate, 3, 0, 3, 0));
    pending_items.push_back(make_item(idl_pkg::OpConvert, 3, 4095, 0, 0));
    pending_items.push_back(make_item(idl_pkg::OpCalibrate, 0, 0, 30, 10));
    pending_items.push_back(make_item(idl_pkg::OpConvert, 0, 4095, 0, 0));
    pending_items.push_back(make_item(idl_pkg::OpConvert, 0, 1449, 0, 0));
    drain();

    // Random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_phase = idle_phase_e'(ph);
      repeat (220) pending_items.push_back(rand_item());
      drain();
    end

    // Long receiver hold-off while the sender keeps offering
    idle_phase = PhNone;
    hold_req = 1'b1;
    repeat (60) pending_items.push_back(rand_item());
    wait (hold_done);
    drain();
    repeat (80) pending_items.push_back(rand_item());
    drain();

    repeat (Latency + 10) @(posedge clk_i);
    $display("covered %0d conversions, %0d calibrations, %0d results checked",
             n_conv, n_cal, results_seen);
    $display("saturated results %0d, rejected writes %0d", n_sat, n_rej);
    if (errors == 0) begin
      $display("ir_distance_linearizer_unit: match");
    end else begin
      $display("ir_distance_linearizer_unit: mismatch");
    end
    $finish;
  end
endmodule
